### rtl/kthrs_pkg.sv
// Shared constants for the kth-remaining select-and-remove unit.
// No dependencies; imported by kth_remaining_select_remove_unit.
package kthrs_pkg;

  // Default number of leaf positions the count tree covers.
  localparam int DefMaxItems = 1024;

  // Field widths of the request and result.
  localparam int RankW     = 11;
  localparam int PositionW = 11;
  localparam int RemainW   = 11;
  localparam int ItemCntW  = 11;

  // Padded stream widths.
  localparam int SDataW = 16;
  localparam int MDataW = 24;

  // Register reset value of item_count.
  localparam int ItemCountReset = 1024;

  // Result status codes.
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

endpackage

### rtl/kth_remaining_select_remove_unit.sv
// Kth-remaining select-and-remove over a count tree held in one block memory.
// Depends on kthrs_pkg (widths, reset value, status codes).

// Each request carries a 1-based rank k among the leaf positions still present.
// The unit walks the count tree from the root to a leaf, one tree level per
// cycle: it reads the left child count, decrements the current node and steps
// left or right. The walk shares one single-port-write, one-port-read memory,
// which sets the pace. A valid request walks the tree levels, then a leaf state
// drops the leaf and a final state loads the output register; no new request
// is taken until the unit is back in idle. A rank of zero or above the
// remaining count goes straight to the final state, which loads its flagged
// result, and the tree stays untouched. A result held back by the receiver
// stalls the unit before it loads the output register. After reset and after
// every item_count write, the tree is rebuilt by a sweep over all
// 2 * leaves - 1 nodes, one node a cycle; no request is taken during the sweep.
// The result sits in an output register, so the next request may be taken
// while a result still waits. item_count above MAX_ITEMS saturates to it.
module kth_remaining_select_remove_unit
  import kthrs_pkg::*;
#(
  parameter int MAX_ITEMS = DefMaxItems
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration: item_count
  input  logic              cfg_we_i,
  input  logic [ItemCntW-1:0] cfg_wdata_i,
  // Request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SDataW-1:0] s_axis_tdata,   // [10:0] rank, [15:11] zero
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [MDataW-1:0] m_axis_tdata,   // [10:0] position, [21:11] remaining,
                                            // [23:22] zero
  output logic              m_axis_tuser    // [0] status
);

  // Tree geometry.
  localparam int Levels = $clog2(MAX_ITEMS);
  localparam int Leaves = 1 << Levels;
  localparam int IW     = Levels + 1;                 // node index width
  localparam int SW     = Levels + 1;                 // leaf span / start width
  localparam int CW     = $clog2(MAX_ITEMS + 1);      // count width
  localparam int VW     = (CW > RankW) ? CW : RankW;  // rank check width
  localparam int NReset = (ItemCountReset > MAX_ITEMS) ? MAX_ITEMS : ItemCountReset;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_LEAF,
    ST_FIN
  } state_e;

  // Count tree: node 1 is the root, node i has children 2i and 2i+1.
  logic [CW-1:0] tree_mem [2*Leaves];
  logic [CW-1:0] rd_data_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  state_e        state_q, state_d;
  logic [CW-1:0] n_q, n_d;            // saturated item_count
  logic [CW-1:0] total_q, total_d;    // mirror of the root count
  logic [IW-1:0] node_q, node_d;
  logic [CW-1:0] cur_q, cur_d;        // count of node_q
  logic [CW-1:0] k_q, k_d;
  logic [IW-1:0] sweep_q, sweep_d;
  logic [SW-1:0] span_q, span_d;      // leaves below the swept node
  logic [SW-1:0] start_q, start_d;    // first leaf below the swept node
  logic [PositionW-1:0] res_pos_q, res_pos_d;
  logic          res_stat_q, res_stat_d;
  logic          m_valid_q, m_valid_d;
  logic [PositionW-1:0] out_pos_q, out_pos_d;
  logic [RemainW-1:0]   out_rem_q, out_rem_d;
  logic          out_stat_q, out_stat_d;

  logic [RankW-1:0] rank;
  logic          rank_ok;
  logic          go_right;
  logic [IW-1:0] child;
  logic [SW:0]   span_end;
  logic [SW-1:0] n_ext;
  logic [SW-1:0] avail;
  logic [CW-1:0] sweep_val;
  logic [CW-1:0] n_cfg;
  logic [31:0]   pos_wide;
  logic [31:0]   rem_wide;

  assign rank    = s_axis_tdata[RankW-1:0];
  assign rank_ok = (rank != '0) && (VW'(rank) <= VW'(total_q));

  // Walk step: left child count arrives in rd_data_q.
  assign go_right = (rd_data_q < k_q);
  assign child    = {node_q[IW-2:0], go_right};

  // Rebuild value of the swept node: present leaves within its range.
  assign span_end  = {1'b0, start_q} + {1'b0, span_q};
  assign n_ext     = SW'(n_q);
  assign avail     = n_ext - start_q;
  assign sweep_val = (n_ext <= start_q) ? '0 :
                     (avail > span_q)   ? CW'(span_q) : CW'(avail);

  assign n_cfg = (32'(cfg_wdata_i) > MAX_ITEMS) ? CW'(MAX_ITEMS) : CW'(cfg_wdata_i);

  assign pos_wide = 32'(node_q[Levels-1:0]) + 32'd1;
  assign rem_wide = 32'(total_q);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    total_d    = total_q;
    node_d     = node_q;
    cur_d      = cur_q;
    k_d        = k_q;
    sweep_d    = sweep_q;
    span_d     = span_q;
    start_d    = start_q;
    res_pos_d  = res_pos_q;
    res_stat_d = res_stat_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    out_pos_d  = out_pos_q;
    out_rem_d  = out_rem_q;
    out_stat_d = out_stat_q;
    rd_addr    = IW'(2);
    wr_en      = 1'b0;
    wr_addr    = node_q;
    wr_data    = cur_q - CW'(1);

    case (state_q)
      ST_CLEAR: begin
        // Write one node a cycle; step start per node and halve span per level.
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wr_data = sweep_val;
        sweep_d = sweep_q + IW'(1);
        if (span_end == (SW + 1)'(Leaves)) begin
          span_d  = span_q >> 1;
          start_d = '0;
        end else begin
          start_d = span_end[SW-1:0];
        end
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Root's left child is read every idle cycle.
        if (s_axis_tvalid) begin
          if (rank_ok) begin
            node_d  = IW'(1);
            cur_d   = total_q;
            k_d     = CW'(rank);
            state_d = ST_WALK;
          end else begin
            res_pos_d  = '0;
            res_stat_d = StatusBad;
            state_d    = ST_FIN;
          end
        end
      end
      ST_WALK: begin
        // Decrement this node and step to the chosen child.
        wr_en  = 1'b1;
        node_d = child;
        if (go_right) begin
          cur_d = cur_q - rd_data_q;
          k_d   = k_q - rd_data_q;
        end else begin
          cur_d = rd_data_q;
        end
        rd_addr = {child[IW-2:0], 1'b0};
        if (child[IW-1]) begin
          state_d = ST_LEAF;
        end
      end
      ST_LEAF: begin
        // Drop the leaf itself.
        wr_en      = 1'b1;
        total_d    = total_q - CW'(1);
        res_pos_d  = pos_wide[PositionW-1:0];
        res_stat_d = StatusOk;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free.
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_pos_d  = res_pos_q;
          out_rem_d  = rem_wide[RemainW-1:0];
          out_stat_d = res_stat_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A write of item_count restarts the rebuild sweep.
    if (cfg_we_i) begin
      n_d     = n_cfg;
      total_d = n_cfg;
      sweep_d = IW'(1);
      span_d  = SW'(Leaves);
      start_d = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      n_q        <= CW'(NReset);
      total_q    <= CW'(NReset);
      sweep_q    <= IW'(1);
      span_q     <= SW'(Leaves);
      start_q    <= '0;
      m_valid_q  <= 1'b0;
      out_pos_q  <= '0;
      out_rem_q  <= '0;
      out_stat_q <= StatusOk;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      total_q    <= total_d;
      sweep_q    <= sweep_d;
      span_q     <= span_d;
      start_q    <= start_d;
      m_valid_q  <= m_valid_d;
      out_pos_q  <= out_pos_d;
      out_rem_q  <= out_rem_d;
      out_stat_q <= out_stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    cur_q      <= cur_d;
    k_q        <= k_d;
    res_pos_q  <= res_pos_d;
    res_stat_q <= res_stat_d;
  end

  // Count tree memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= tree_mem[rd_addr];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_rem_q, out_pos_q};
  assign m_axis_tuser  = out_stat_q;

endmodule
